### design/gle_pkg.sv
// Shared types, constants and helpers for the gray Laplacian edge filter.
`timescale 1ns / 1ps

package gle_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 2048;
	localparam int unsigned DEF_MAX_HEIGHT = 2048;

	localparam int unsigned CFG_W     = 12;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned POS_W     = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

	// Q0.16 luma weights: 0.114, 0.587, 0.299
	localparam logic [15:0] GRAY_WB = 16'd7471;
	localparam logic [15:0] GRAY_WG = 16'd38470;
	localparam logic [15:0] GRAY_WR = 16'd19595;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last_item;
		logic             last_frame;
	} gle_res_t;

	function automatic logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v, int unsigned maxv);
		logic [CFG_W-1:0] r;
		if (v == '0)
			r = CFG_W'(1);
		else if (32'(v) > maxv)
			r = CFG_W'(maxv);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] to_gray(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
		logic [PIX_W-1:0] r);
		logic [23:0] acc;
		acc = 24'(GRAY_WB) * 24'(b) + 24'(GRAY_WG) * 24'(g) + 24'(GRAY_WR) * 24'(r);
		return acc[23:16];
	endfunction

endpackage

### design/gray_laplace_edge_filter.sv
// Top level: BGR to gray conversion and 3x3 Laplacian edge filter over a line memory.
`timescale 1ns / 1ps

// Pixels enter on the s_ channel in raster order, one BGR pixel per transfer.
// Each pixel is converted to gray and stored in a line memory that holds the
// previous and the one-before-previous row (one 16-bit word per column).
// Pixel (r-1, c) is emitted on the m_ channel when pixel (r, c) arrives: interior
// pixels give the saturated |4c-n-s-e-w|, border pixels their gray value. Pixels
// of the last row are also emitted directly, so one input gives 0, 1 or 2 results.
// Throughput: one pixel per cycle while the output does not stall, limited by the
// single read and write port of the line memory (one read-modify-write per pixel);
// on the last row of a frame taller than one row each pixel gives two output results.
// Configuration writes (image_width, image_height) restart the frame at row 0,
// column 0 and must happen while the block is idle.
// Reset clears the raster position and the pipeline and loads 640 x 480; the
// line memory is not cleared, every entry is written before it is used.
// When the receiver stalls, results wait in the output stage and s_tready drops
// once the internal stage behind it is full.
module gray_laplace_edge_filter
	import gle_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,  // blue, green, red
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,  // out_row, out_col, edge_value, zero pad
	output logic                 m_tlast,  // last_of_frame
	output logic                 m_tuser   // last_of_item
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned XW = AW + CFG_W + 1;
	localparam int unsigned YW = RW + CFG_W + 1;
	localparam logic [CFG_W-1:0] W_RST = eff_size(WIDTH_RST, MAX_WIDTH);
	localparam logic [CFG_W-1:0] H_RST = eff_size(HEIGHT_RST, MAX_HEIGHT);

	typedef struct packed {
		logic [PIX_W-1:0] two_above;
		logic [PIX_W-1:0] above;
	} lb_word_t;

	lb_word_t lbuf_mem [MAX_WIDTH];
	lb_word_t lbuf_rd_q;
	lb_word_t wr_word;

	logic [CFG_W-1:0] w_eff_q, h_eff_q;
	logic [AW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] west_q;

	logic             in_xfer, m_xfer;
	logic [PIX_W-1:0] gray_in;
	logic             last_col, last_row;
	logic [AW-1:0]    rd_addr;

	logic             s1_valid;
	logic [RW-1:0]    row_s1;
	logic [AW-1:0]    col_s1;
	logic [PIX_W-1:0] gray_s1, ctr_s1, north_s1, west_s1;
	logic             inner_s1, emit_a_s1, emit_b_s1, last_col_s1;

	logic signed [11:0] lap;
	logic [11:0]        lap_abs;
	logic [PIX_W-1:0]   edge_val;
	gle_res_t           res_a, res_b, res_out;

	logic     s2_valid, two_q, sel_q;
	gle_res_t res0_s2, res1_s2;
	logic     s2_on_last, s2_free;

	assign in_xfer  = s_tvalid && s_tready;
	assign m_xfer   = m_tvalid && m_tready;
	assign gray_in  = to_gray(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
	assign last_col = (XW'(col_q) + XW'(1)) == XW'(w_eff_q);
	assign last_row = (YW'(row_q) + YW'(1)) == YW'(h_eff_q);
	assign rd_addr  = last_col ? '0 : col_q + AW'(1);
	assign wr_word  = '{two_above: lbuf_rd_q.above, above: gray_in};

	// line memory: read next column, write current column back
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lbuf_mem[col_q] <= wr_word;
			if (rd_addr == col_q)
				lbuf_rd_q <= wr_word;
			else
				lbuf_rd_q <= lbuf_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= W_RST;
			h_eff_q <= H_RST;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  w_eff_q <= eff_size(cfg_data, MAX_WIDTH);
				REG_IMAGE_HEIGHT: h_eff_q <= eff_size(cfg_data, MAX_HEIGHT);
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			west_q      <= lbuf_rd_q.above;
			row_s1      <= row_q;
			col_s1      <= col_q;
			gray_s1     <= gray_in;
			ctr_s1      <= lbuf_rd_q.above;
			north_s1    <= lbuf_rd_q.two_above;
			west_s1     <= west_q;
			inner_s1    <= (row_q > RW'(1)) && (col_q != '0) && !last_col;
			emit_a_s1   <= row_q != '0;
			emit_b_s1   <= last_row;
			last_col_s1 <= last_col;
		end
	end

	// east neighbour is the word read ahead for the next column
	always_comb begin
		lap = $signed({2'b00, ctr_s1, 2'b00}) - $signed(12'(north_s1)) -
			$signed(12'(gray_s1)) - $signed(12'(west_s1)) - $signed(12'(lbuf_rd_q.above));
		lap_abs  = lap[11] ? 12'(-lap) : 12'(lap);
		edge_val = (lap_abs > 12'(PIX_MAX)) ? PIX_MAX : lap_abs[PIX_W-1:0];
	end

	always_comb begin
		res_a.value      = inner_s1 ? edge_val : ctr_s1;
		res_a.col        = POS_W'(col_s1);
		res_a.row        = POS_W'(row_s1 - RW'(1));
		res_a.last_item  = !emit_b_s1;
		res_a.last_frame = 1'b0;
		res_b.value      = gray_s1;
		res_b.col        = POS_W'(col_s1);
		res_b.row        = POS_W'(row_s1);
		res_b.last_item  = 1'b1;
		res_b.last_frame = last_col_s1;
	end

	assign s2_on_last = !two_q || sel_q;
	assign s2_free    = !s2_valid || (m_tready && s2_on_last);
	assign s_tready   = !s1_valid || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			two_q    <= 1'b0;
			sel_q    <= 1'b0;
		end else begin
			if (s_tready)
				s1_valid <= s_tvalid;
			if (s2_free) begin
				s2_valid <= s1_valid && (emit_a_s1 || emit_b_s1);
				two_q    <= emit_a_s1 && emit_b_s1;
				sel_q    <= 1'b0;
			end else if (m_xfer) begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_valid) begin
			res0_s2 <= emit_a_s1 ? res_a : res_b;
			res1_s2 <= res_b;
		end
	end

	assign res_out  = sel_q ? res1_s2 : res0_s2;
	assign m_tvalid = s2_valid;
	assign m_tdata  = {2'b00, res_out.value, res_out.col, res_out.row};
	assign m_tlast  = res_out.last_frame;
	assign m_tuser  = res_out.last_item;

	a_sel_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (s2_valid && two_q))
		else $error("second slot selected without a pair");

	a_east_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s2_free) |=> $stable(lbuf_rd_q))
		else $error("read-ahead word changed under a stalled pixel");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("frame end not on last result of its pixel");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(col_q) < XW'(w_eff_q))
		else $error("column counter outside frame");

endmodule

### verif/tb_gray_laplace_edge_filter.sv
// Self-checking testbench for the gray Laplacian edge filter: directed table, random frames, width clamp.
`timescale 1ns / 1ps

module tb_gray_laplace_edge_filter;
	import gle_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned RANDOM_ITEMS  = 83;
	localparam int unsigned FRAME_CAP     = 24;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	typedef enum logic { STEP_PIXEL, STEP_WRITE } step_kind_t;

	typedef struct {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     value;
		logic [7:0]           b;
		logic [7:0]           g;
		logic [7:0]           r;
		bit                   known;
		logic [7:0]           known_val;
	} dir_step_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata   = '0;  // blue, green, red
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [31:0]          m_tdata;         // out_row, out_col, edge_value, zero pad
	logic                 m_tlast;         // last_of_frame
	logic                 m_tuser;         // last_of_item

	gray_laplace_edge_filter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// filter state mirror
	bit [7:0]         gray_above     [0:DEF_MAX_WIDTH-1];
	bit [7:0]         gray_two_above [0:DEF_MAX_WIDTH-1];
	int unsigned      west_tap;
	int unsigned      pos_row;
	int unsigned      pos_col;
	logic [CFG_W-1:0] cfg_width  = WIDTH_RST;
	logic [CFG_W-1:0] cfg_height = HEIGHT_RST;

	gle_res_t    expected_q[$];
	int unsigned mismatches  = 0;
	int unsigned cycles      = 0;
	int unsigned tx_idle_pct = 30;
	int unsigned rx_idle_pct = 80;
	bit          hold_req    = 1'b0;

	dir_step_t directed_steps [0:26] = '{
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
		'{STEP_WRITE, REG_IMAGE_WIDTH,  12'd3, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
		'{STEP_WRITE, REG_IMAGE_HEIGHT, 12'd3, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
		// 3x3 black with white centre
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
		// next frame, same size: white with black centre
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
		// zero width acts as one; single row: gray passes straight out
		'{STEP_WRITE, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
		'{STEP_WRITE, REG_IMAGE_HEIGHT, 12'd1, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd255, 8'd0,   8'd0,   1'b1, 8'd29},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd255, 8'd0,   1'b1, 8'd149},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  12'd0, 8'd0,   8'd0,   8'd255, 1'b1, 8'd76}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
		if (v == '0)
			return 1;
		if (32'(v) > maxv)
			return maxv;
		return 32'(v);
	endfunction

	// Runs one pixel through the mirror and queues the results it releases.
	function automatic void predict_pixel(input logic [7:0] b, input logic [7:0] g,
		input logic [7:0] r, input bit known, input logic [7:0] known_val);
		int unsigned w, h, rr, cc, gray, west, ctr, n;
		int          sum;
		gle_res_t    res[2];
		w = clamp_size(cfg_width, DEF_MAX_WIDTH);
		h = clamp_size(cfg_height, DEF_MAX_HEIGHT);
		if (pos_col >= w)
			pos_col = 0;
		if (pos_row >= h)
			pos_row = 0;
		rr = pos_row;
		cc = pos_col;
		gray = (32'd7471 * 32'(b) + 32'd38470 * 32'(g) + 32'd19595 * 32'(r)) >> 16;
		west = west_tap;
		west_tap = 32'(gray_above[cc]);
		n = 0;
		if (rr >= 1) begin
			ctr = 32'(gray_above[cc]);
			if (rr >= 2 && cc >= 1 && cc + 1 < w) begin
				sum = 4 * int'(ctr) - int'(gray_two_above[cc]) - int'(gray) - int'(west)
					- int'(gray_above[cc + 1]);
				if (sum < 0)
					sum = -sum;
				if (sum > 255)
					sum = 255;
				ctr = 32'(sum);
			end
			res[n] = '{value: ctr[7:0], col: cc[POS_W-1:0], row: POS_W'(rr - 1),
				last_item: 1'b0, last_frame: 1'b0};
			n++;
		end
		gray_two_above[cc] = gray_above[cc];
		gray_above[cc] = gray[7:0];
		if (rr + 1 == h) begin
			res[n] = '{value: gray[7:0], col: cc[POS_W-1:0], row: rr[POS_W-1:0],
				last_item: 1'b0, last_frame: (cc + 1 == w)};
			n++;
		end
		if (n > 0) begin
			res[n - 1].last_item = 1'b1;
			if (known)
				res[0].value = known_val;
		end
		for (int i = 0; i < n; i++)
			expected_q.push_back(res[i]);
		if (cc + 1 >= w) begin
			pos_col = 0;
			pos_row = (rr + 1 >= h) ? 0 : rr + 1;
		end else begin
			pos_col = cc + 1;
		end
	endfunction

	function automatic logic [7:0] rand_channel();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
		input bit known, input logic [7:0] known_val);
		bit done;
		done = 1'b0;
		while (!done) begin
			if ($urandom_range(0, 99) < tx_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= {r, g, b};
				@(posedge clk);
				while (!s_tready)
					@(posedge clk);
				predict_pixel(b, g, r, known, known_val);
				done = 1'b1;
			end
		end
	endtask

	// Only while idle: drain, let the pipeline settle, then write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			cfg_width = value;
		else
			cfg_height = value;
		pos_row = 0;
		pos_col = 0;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		gle_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected transfer: row %0d col %0d value %0d",
					m_tdata[POS_W-1:0], m_tdata[2*POS_W-1:POS_W],
					m_tdata[2*POS_W+PIX_W-1:2*POS_W]);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_field("out_row", 32'(want.row), 32'(m_tdata[POS_W-1:0]));
				check_field("out_col", 32'(want.col), 32'(m_tdata[2*POS_W-1:POS_W]));
				check_field("edge_value", 32'(want.value),
					32'(m_tdata[2*POS_W+PIX_W-1:2*POS_W]));
				check_field("last_of_item", 32'(want.last_item), 32'(m_tuser));
				check_field("last_of_frame", 32'(want.last_frame), 32'(m_tlast));
			end
		end
	end

	initial begin
		int unsigned rand_items, w, h, count, full;
		bit          hold_phase, hold_done;
		pos_row  = 0;
		pos_col  = 0;
		west_tap = 0;
		wait (arst_n);
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_WRITE)
				write_reg(directed_steps[i].idx, directed_steps[i].value);
			else
				push_pixel(directed_steps[i].b, directed_steps[i].g, directed_steps[i].r,
					directed_steps[i].known, directed_steps[i].known_val);
		end

		rand_items = 0;
		hold_done  = 1'b0;
		while (rand_items < RANDOM_ITEMS) begin
			if (rand_items >= 56) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (rand_items >= 28) begin
				tx_idle_pct = 80;
				rx_idle_pct = 30;
			end
			hold_phase = !hold_done && rand_items >= 32;
			if (hold_phase) begin
				// single row: every transfer yields a result, so the stall backs up fast
				w     = $urandom_range(2, 6);
				h     = 1;
				count = 24;
			end else begin
				w     = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
				h     = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
				full  = 2 * clamp_size(CFG_W'(w), DEF_MAX_WIDTH)
					* clamp_size(CFG_W'(h), DEF_MAX_HEIGHT) + 2;
				count = $urandom_range(1, (full > FRAME_CAP) ? FRAME_CAP : full);
			end
			if (count > RANDOM_ITEMS - rand_items)
				count = RANDOM_ITEMS - rand_items;
			write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
			write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
			for (int i = 0; i < count; i++) begin
				if (hold_phase && i == 2) begin
					hold_req  = 1'b1;
					hold_done = 1'b1;
				end
				push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 8'd0);
				rand_items++;
			end
		end

		// oversized width clamps to the maximum
		write_reg(REG_IMAGE_WIDTH, 12'd4095);
		write_reg(REG_IMAGE_HEIGHT, 12'd1);
		for (int i = 0; i < 4; i++)
			push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 8'd0);

		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### gray_laplace_edge_filter.f
design/gle_pkg.sv
design/gray_laplace_edge_filter.sv
verif/tb_gray_laplace_edge_filter.sv
